// ===== src/pgftl_pkg.sv =====
// Shared types and constants of the page-mapped flash translation block.
// Used by the controller, the RAM wrapper users and the top level.
package pgftl_pkg;

    localparam int PHYSICAL_BLOCKS_DEF = 16;
    localparam int PAGES_PER_BLOCK_DEF = 8;
    localparam int LOGICAL_PAGES_DEF   = 96;

    // Fixed field widths of the stream payloads.
    localparam int OPCODE_W = 2;
    localparam int LPAGE_W  = 7;
    localparam int CMD_W    = 3;
    localparam int BLOCK_W  = 4;
    localparam int PAGE_W   = 3;
    localparam int IN_W     = 16;
    localparam int OUT_W    = 32;

    localparam logic [OPCODE_W-1:0] OP_READ   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_WRITE  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_FORMAT = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ         = 3'd0,
        CMD_UNMAPPED     = 3'd1,
        CMD_PROGRAM      = 3'd2,
        CMD_COPY         = 3'd3,
        CMD_ERASE        = 3'd4,
        CMD_OUT_OF_SPACE = 3'd5,
        CMD_FORMAT_DONE  = 3'd6
    } cmd_t;

    localparam logic [1:0] ST_UNWRITTEN = 2'd0;
    localparam logic [1:0] ST_LIVE      = 2'd1;
    localparam logic [1:0] ST_STALE     = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_FMT, S_OOS, S_WR_OLD, S_SCAN, S_DECIDE, S_CP_RD,
        S_CP_CHK, S_ALLOC, S_SRCH, S_CP_SRC, S_CP_DST, S_ERASE, S_PROG
    } state_t;

    typedef struct packed {
        cmd_t                command;
        logic [BLOCK_W-1:0]  target_block;
        logic [PAGE_W-1:0]   target_page;
        logic [BLOCK_W-1:0]  source_block;
        logic [PAGE_W-1:0]   source_page;
        logic [LPAGE_W-1:0]  mapped_page;
        logic                room_error;
        logic                last;
    } out_t;

endpackage

// ===== src/pgftl_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module pgftl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/pgftl_ctrl.sv =====
// Sequencer of the translation block: request decode, victim scan, copy,
// erase, page allocation and result register. Depends on pgftl_pkg.
module pgftl_ctrl #(
    parameter int PHYSICAL_BLOCKS = pgftl_pkg::PHYSICAL_BLOCKS_DEF,
    parameter int PAGES_PER_BLOCK = pgftl_pkg::PAGES_PER_BLOCK_DEF,
    parameter int LOGICAL_PAGES   = pgftl_pkg::LOGICAL_PAGES_DEF,
    localparam int BW = $clog2(PHYSICAL_BLOCKS),
    localparam int PW = $clog2(PAGES_PER_BLOCK),
    localparam int PA = BW + PW,
    localparam int PD = PHYSICAL_BLOCKS << PW,
    localparam int LW = $clog2(LOGICAL_PAGES),
    localparam int FW = $clog2(PHYSICAL_BLOCKS + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [pgftl_pkg::OPCODE_W-1:0]      in_opcode,
    input  logic [pgftl_pkg::LPAGE_W-1:0]       in_lpage,
    output logic                                out_valid,
    input  logic                                out_ready,
    output pgftl_pkg::out_t                     out_item,
    // Logical map RAM port.
    output logic                                lm_we,
    output logic [LW-1:0]                       lm_waddr,
    output logic [PA-1:0]                       lm_wdata,
    output logic                                lm_re,
    output logic [LW-1:0]                       lm_raddr,
    input  logic [PA-1:0]                       lm_rdata,
    // Physical map RAM port: {status, logical page}.
    output logic                                pm_we,
    output logic [PA-1:0]                       pm_waddr,
    output logic [LW+1:0]                       pm_wdata,
    output logic                                pm_re,
    output logic [PA-1:0]                       pm_raddr,
    input  logic [LW+1:0]                       pm_rdata,
    output logic [FW-1:0]                       free_count,
    output logic [PHYSICAL_BLOCKS-1:0]          free_mask
);

    pgftl_pkg::state_t state_reg, state_next;

    logic [LOGICAL_PAGES-1:0]    lvalid_reg, lvalid_next;
    logic [PD-1:0]               pvalid_reg, pvalid_next;
    logic [PHYSICAL_BLOCKS-1:0]  bfree_reg, bfree_next;
    logic [BW-1:0]               ab_reg, ab_next;
    logic [PW-1:0]               ap_reg, ap_next;
    logic                        started_reg, started_next;
    logic [FW-1:0]               free_reg, free_next;

    logic [pgftl_pkg::LPAGE_W-1:0] lp_reg, lp_next;
    logic                        room_reg, room_next;
    logic [BW-1:0]               scan_b_reg, scan_b_next, d_b_reg, d_b_next;
    logic [PW-1:0]               scan_p_reg, scan_p_next, d_p_reg, d_p_next;
    logic                        issued_reg, issued_next, d_valid_reg, d_valid_next;
    logic [PW:0]                 cnt_reg, cnt_next, most_reg, most_next;
    logic [BW-1:0]               victim_reg, victim_next;
    logic [PW-1:0]               cp_p_reg, cp_p_next;
    logic [LW-1:0]               cp_lp_reg, cp_lp_next;
    logic                        ret_copy_reg, ret_copy_next;
    logic                        alloc_ok_reg, alloc_ok_next;
    logic [BW-1:0]               srch_b_reg, srch_b_next;
    logic [BW-1:0]               srch_n_reg, srch_n_next;
    logic                        out_valid_reg, out_valid_next;
    pgftl_pkg::out_t             out_reg, out_next;

    logic          slot_free;
    logic          lp_in_range;
    logic [LW-1:0] lidx;
    logic [1:0]    pm_status;
    logic [LW-1:0] pm_lpage;
    logic [PA-1:0] cp_addr;
    logic          cp_live;
    logic          d_stale;
    logic [PW:0]   blk_cnt;
    logic [PW+1:0] need;
    logic          page_full;
    logic          last_issue;

    assign slot_free   = !out_valid_reg || out_ready;
    assign lp_in_range = 32'(lp_reg) < LOGICAL_PAGES;
    assign lidx        = LW'(lp_reg);
    assign pm_status   = pm_rdata[LW+1:LW];
    assign pm_lpage    = pm_rdata[LW-1:0];
    assign cp_addr     = {victim_reg, cp_p_reg};
    assign cp_live     = pvalid_reg[cp_addr] && (pm_status == pgftl_pkg::ST_LIVE);
    assign d_stale     = d_valid_reg && pvalid_reg[{d_b_reg, d_p_reg}]
                         && (pm_status == pgftl_pkg::ST_STALE);
    assign blk_cnt     = cnt_reg + (PW+1)'(d_stale);
    assign need        = (PW+2)'(ap_reg) + (PW+2)'(1)
                         + (PW+2)'(PAGES_PER_BLOCK) - (PW+2)'(most_reg);
    assign page_full   = 32'(ap_reg) + 1 >= PAGES_PER_BLOCK;
    assign last_issue  = (32'(scan_p_reg) == PAGES_PER_BLOCK - 1)
                         && (32'(scan_b_reg) == PHYSICAL_BLOCKS - 1);

    assign in_ready   = (state_reg == pgftl_pkg::S_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_item   = out_reg;
    assign free_count = free_reg;
    assign free_mask  = bfree_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pgftl_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_opcode)
                        pgftl_pkg::OP_READ:   state_next = pgftl_pkg::S_READ;
                        pgftl_pkg::OP_FORMAT: state_next = pgftl_pkg::S_FMT;
                        pgftl_pkg::OP_WRITE:
                        begin
                            if (32'(in_lpage) < LOGICAL_PAGES)
                                state_next = pgftl_pkg::S_WR_OLD;
                            else
                                state_next = pgftl_pkg::S_OOS;
                        end
                        default: state_next = pgftl_pkg::S_IDLE;
                    endcase
                end
            end
            pgftl_pkg::S_READ, pgftl_pkg::S_FMT, pgftl_pkg::S_OOS, pgftl_pkg::S_PROG:
            begin
                if (slot_free)
                    state_next = pgftl_pkg::S_IDLE;
            end
            pgftl_pkg::S_WR_OLD:
            begin
                if (free_reg == '0)
                    state_next = pgftl_pkg::S_SCAN;
                else
                    state_next = pgftl_pkg::S_ALLOC;
            end
            pgftl_pkg::S_SCAN:
            begin
                if (issued_reg && !d_valid_reg)
                    state_next = pgftl_pkg::S_DECIDE;
            end
            pgftl_pkg::S_DECIDE:
            begin
                if (most_reg == '0 || 32'(need) < PAGES_PER_BLOCK)
                    state_next = pgftl_pkg::S_ALLOC;
                else
                    state_next = pgftl_pkg::S_CP_RD;
            end
            pgftl_pkg::S_CP_RD: state_next = pgftl_pkg::S_CP_CHK;
            pgftl_pkg::S_CP_CHK:
            begin
                if (cp_live)
                    state_next = pgftl_pkg::S_ALLOC;
                else if (32'(cp_p_reg) == PAGES_PER_BLOCK - 1)
                    state_next = pgftl_pkg::S_ERASE;
                else
                    state_next = pgftl_pkg::S_CP_RD;
            end
            pgftl_pkg::S_ALLOC:
            begin
                if (!started_reg || !page_full)
                    state_next = ret_copy_reg ? pgftl_pkg::S_CP_SRC : pgftl_pkg::S_PROG;
                else
                    state_next = pgftl_pkg::S_SRCH;
            end
            pgftl_pkg::S_SRCH:
            begin
                if (bfree_reg[srch_b_reg])
                    state_next = ret_copy_reg ? pgftl_pkg::S_CP_SRC : pgftl_pkg::S_PROG;
                else if (32'(srch_n_reg) == PHYSICAL_BLOCKS - 1)
                    // A copy with no room ends the collection; the write retries.
                    state_next = ret_copy_reg ? pgftl_pkg::S_ALLOC : pgftl_pkg::S_PROG;
            end
            pgftl_pkg::S_CP_SRC: state_next = pgftl_pkg::S_CP_DST;
            pgftl_pkg::S_CP_DST:
            begin
                if (slot_free)
                begin
                    if (32'(cp_p_reg) == PAGES_PER_BLOCK - 1)
                        state_next = pgftl_pkg::S_ERASE;
                    else
                        state_next = pgftl_pkg::S_CP_RD;
                end
            end
            pgftl_pkg::S_ERASE:
            begin
                if (slot_free)
                    state_next = pgftl_pkg::S_ALLOC;
            end
            default: state_next = pgftl_pkg::S_IDLE;
        endcase
    end

    // Datapath, RAM controls and results.
    always_comb
    begin
        lvalid_next    = lvalid_reg;
        pvalid_next    = pvalid_reg;
        bfree_next     = bfree_reg;
        ab_next        = ab_reg;
        ap_next        = ap_reg;
        started_next   = started_reg;
        free_next      = free_reg;
        lp_next        = lp_reg;
        room_next      = room_reg;
        scan_b_next    = scan_b_reg;
        scan_p_next    = scan_p_reg;
        d_b_next       = d_b_reg;
        d_p_next       = d_p_reg;
        issued_next    = issued_reg;
        d_valid_next   = 1'b0;
        cnt_next       = cnt_reg;
        most_next      = most_reg;
        victim_next    = victim_reg;
        cp_p_next      = cp_p_reg;
        cp_lp_next     = cp_lp_reg;
        ret_copy_next  = ret_copy_reg;
        alloc_ok_next  = alloc_ok_reg;
        srch_b_next    = srch_b_reg;
        srch_n_next    = srch_n_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        lm_we    = 1'b0;
        lm_waddr = lidx;
        lm_wdata = {ab_reg, ap_reg};
        lm_re    = 1'b0;
        lm_raddr = LW'(in_lpage);
        pm_we    = 1'b0;
        pm_waddr = {ab_reg, ap_reg};
        pm_wdata = {pgftl_pkg::ST_LIVE, lidx};
        pm_re    = 1'b0;
        pm_raddr = cp_addr;

        if (slot_free)
        begin
            out_next.command      = pgftl_pkg::CMD_OUT_OF_SPACE;
            out_next.target_block = '0;
            out_next.target_page  = '0;
            out_next.source_block = '0;
            out_next.source_page  = '0;
            out_next.mapped_page  = lp_reg;
            out_next.room_error   = room_reg;
            out_next.last         = 1'b1;
        end

        unique case (state_reg)
            pgftl_pkg::S_IDLE:
            begin
                lp_next       = in_lpage;
                room_next     = 1'b0;
                ret_copy_next = 1'b0;
                lm_re         = in_valid && (32'(in_lpage) < LOGICAL_PAGES);
            end
            pgftl_pkg::S_READ:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (lp_in_range && lvalid_reg[lidx])
                    begin
                        out_next.command      = pgftl_pkg::CMD_READ;
                        out_next.target_block = pgftl_pkg::BLOCK_W'(lm_rdata[PA-1:PW]);
                        out_next.target_page  = pgftl_pkg::PAGE_W'(lm_rdata[PW-1:0]);
                    end
                    else
                    begin
                        out_next.command = pgftl_pkg::CMD_UNMAPPED;
                    end
                end
            end
            pgftl_pkg::S_FMT:
            begin
                if (slot_free)
                begin
                    lvalid_next    = '0;
                    pvalid_next    = '0;
                    bfree_next     = '1;
                    ab_next        = '0;
                    ap_next        = '0;
                    started_next   = 1'b0;
                    free_next      = FW'(PHYSICAL_BLOCKS);
                    out_valid_next = 1'b1;
                    out_next.command     = pgftl_pkg::CMD_FORMAT_DONE;
                    out_next.mapped_page = '0;
                end
            end
            pgftl_pkg::S_OOS:
            begin
                if (slot_free)
                    out_valid_next = 1'b1;
            end
            pgftl_pkg::S_WR_OLD:
            begin
                if (lvalid_reg[lidx])
                begin
                    pm_we    = 1'b1;
                    pm_waddr = lm_rdata;
                    pm_wdata = {pgftl_pkg::ST_STALE, lidx};
                    pvalid_next[lm_rdata] = 1'b1;
                    lvalid_next[lidx]     = 1'b0;
                end
                scan_b_next = '0;
                scan_p_next = '0;
                issued_next = 1'b0;
                cnt_next    = '0;
                most_next   = '0;
                victim_next = '0;
            end
            pgftl_pkg::S_SCAN:
            begin
                if (!issued_reg)
                begin
                    pm_re        = 1'b1;
                    pm_raddr     = {scan_b_reg, scan_p_reg};
                    d_valid_next = 1'b1;
                    d_b_next     = scan_b_reg;
                    d_p_next     = scan_p_reg;
                    if (last_issue)
                    begin
                        issued_next = 1'b1;
                    end
                    else if (32'(scan_p_reg) == PAGES_PER_BLOCK - 1)
                    begin
                        scan_p_next = '0;
                        scan_b_next = scan_b_reg + BW'(1);
                    end
                    else
                    begin
                        scan_p_next = scan_p_reg + PW'(1);
                    end
                end
                if (d_valid_reg)
                begin
                    if (32'(d_p_reg) == PAGES_PER_BLOCK - 1)
                    begin
                        cnt_next = '0;
                        if (d_b_reg != ab_reg && blk_cnt > most_reg)
                        begin
                            most_next   = blk_cnt;
                            victim_next = d_b_reg;
                        end
                    end
                    else
                    begin
                        cnt_next = blk_cnt;
                    end
                end
            end
            pgftl_pkg::S_DECIDE:
            begin
                cp_p_next = '0;
                if (most_reg != '0 && 32'(need) > PAGES_PER_BLOCK)
                    room_next = 1'b1;
            end
            pgftl_pkg::S_CP_RD:
            begin
                pm_re = 1'b1;
            end
            pgftl_pkg::S_CP_CHK:
            begin
                cp_lp_next = pm_lpage;
                if (cp_live)
                    ret_copy_next = 1'b1;
                else
                    cp_p_next = cp_p_reg + PW'(1);
            end
            pgftl_pkg::S_ALLOC:
            begin
                srch_b_next = ab_reg;
                srch_n_next = '0;
                if (!started_reg)
                begin
                    started_next  = 1'b1;
                    ab_next       = '0;
                    ap_next       = '0;
                    bfree_next[0] = 1'b0;
                    if (free_reg != '0)
                        free_next = free_reg - FW'(1);
                    alloc_ok_next = 1'b1;
                end
                else if (!page_full)
                begin
                    ap_next       = ap_reg + PW'(1);
                    alloc_ok_next = 1'b1;
                end
            end
            pgftl_pkg::S_SRCH:
            begin
                if (bfree_reg[srch_b_reg])
                begin
                    ab_next                = srch_b_reg;
                    ap_next                = '0;
                    bfree_next[srch_b_reg] = 1'b0;
                    if (free_reg != '0)
                        free_next = free_reg - FW'(1);
                    alloc_ok_next = 1'b1;
                end
                else if (32'(srch_n_reg) == PHYSICAL_BLOCKS - 1)
                begin
                    alloc_ok_next = 1'b0;
                    ret_copy_next = 1'b0;
                end
                else
                begin
                    srch_n_next = srch_n_reg + BW'(1);
                    if (32'(srch_b_reg) == PHYSICAL_BLOCKS - 1)
                        srch_b_next = '0;
                    else
                        srch_b_next = srch_b_reg + BW'(1);
                end
            end
            pgftl_pkg::S_CP_SRC:
            begin
                pm_we    = 1'b1;
                pm_waddr = cp_addr;
                pm_wdata = {pgftl_pkg::ST_STALE, cp_lp_reg};
            end
            pgftl_pkg::S_CP_DST:
            begin
                if (slot_free)
                begin
                    pm_we    = 1'b1;
                    pm_wdata = {pgftl_pkg::ST_LIVE, cp_lp_reg};
                    pvalid_next[{ab_reg, ap_reg}] = 1'b1;
                    if (32'(cp_lp_reg) < LOGICAL_PAGES)
                    begin
                        lm_we    = 1'b1;
                        lm_waddr = cp_lp_reg;
                        lvalid_next[cp_lp_reg] = 1'b1;
                    end
                    ret_copy_next  = 1'b0;
                    cp_p_next      = cp_p_reg + PW'(1);
                    out_valid_next = 1'b1;
                    out_next.command      = pgftl_pkg::CMD_COPY;
                    out_next.target_block = pgftl_pkg::BLOCK_W'(ab_reg);
                    out_next.target_page  = pgftl_pkg::PAGE_W'(ap_reg);
                    out_next.source_block = pgftl_pkg::BLOCK_W'(victim_reg);
                    out_next.source_page  = pgftl_pkg::PAGE_W'(cp_p_reg);
                    out_next.mapped_page  = pgftl_pkg::LPAGE_W'(cp_lp_reg);
                    out_next.last         = 1'b0;
                end
            end
            pgftl_pkg::S_ERASE:
            begin
                if (slot_free)
                begin
                    for (int p = 0; p < PAGES_PER_BLOCK; p++)
                    begin
                        pvalid_next[{victim_reg, PW'(p)}] = 1'b0;
                    end
                    if (!bfree_reg[victim_reg])
                        free_next = free_reg + FW'(1);
                    bfree_next[victim_reg] = 1'b1;
                    ret_copy_next  = 1'b0;
                    out_valid_next = 1'b1;
                    out_next.command      = pgftl_pkg::CMD_ERASE;
                    out_next.target_block = pgftl_pkg::BLOCK_W'(victim_reg);
                    out_next.mapped_page  = '0;
                    out_next.last         = 1'b0;
                end
            end
            pgftl_pkg::S_PROG:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (alloc_ok_reg)
                    begin
                        lm_we = 1'b1;
                        pm_we = 1'b1;
                        lvalid_next[lidx] = 1'b1;
                        pvalid_next[{ab_reg, ap_reg}] = 1'b1;
                        out_next.command      = pgftl_pkg::CMD_PROGRAM;
                        out_next.target_block = pgftl_pkg::BLOCK_W'(ab_reg);
                        out_next.target_page  = pgftl_pkg::PAGE_W'(ap_reg);
                    end
                end
            end
            default:
            begin
                lm_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pgftl_pkg::S_IDLE;
            lvalid_reg    <= '0;
            pvalid_reg    <= '0;
            bfree_reg     <= '1;
            ab_reg        <= '0;
            ap_reg        <= '0;
            started_reg   <= 1'b0;
            free_reg      <= FW'(PHYSICAL_BLOCKS);
            issued_reg    <= 1'b0;
            d_valid_reg   <= 1'b0;
            ret_copy_reg  <= 1'b0;
            alloc_ok_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lvalid_reg    <= lvalid_next;
            pvalid_reg    <= pvalid_next;
            bfree_reg     <= bfree_next;
            ab_reg        <= ab_next;
            ap_reg        <= ap_next;
            started_reg   <= started_next;
            free_reg      <= free_next;
            issued_reg    <= issued_next;
            d_valid_reg   <= d_valid_next;
            ret_copy_reg  <= ret_copy_next;
            alloc_ok_reg  <= alloc_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lp_reg     <= lp_next;
        room_reg   <= room_next;
        scan_b_reg <= scan_b_next;
        scan_p_reg <= scan_p_next;
        d_b_reg    <= d_b_next;
        d_p_reg    <= d_p_next;
        cnt_reg    <= cnt_next;
        most_reg   <= most_next;
        victim_reg <= victim_next;
        cp_p_reg   <= cp_p_next;
        cp_lp_reg  <= cp_lp_next;
        srch_b_reg <= srch_b_next;
        srch_n_reg <= srch_n_next;
        out_reg    <= out_next;
    end

endmodule

// ===== src/page_map_ftl_greedy_gc_top.sv =====
// Page-mapped translation block with greedy garbage collection.
// Read, format and out-of-range write are each answered from a single result state.
// Write: the old page is marked stale, then a page is allocated and programmed; a victim
// scan over every physical page (PHYSICAL_BLOCKS*PAGES_PER_BLOCK) runs when no erased
// block is left, then, if a victim is collected, a check of each victim page, a copy of each
// live one, the erase and, when the active block is full, a search over up to PHYSICAL_BLOCKS blocks.
// Reset (rst_n low, asynchronous) leaves every map empty; no clearing pass.
module page_map_ftl_greedy_gc_top #(
    parameter int PHYSICAL_BLOCKS = pgftl_pkg::PHYSICAL_BLOCKS_DEF,
    parameter int PAGES_PER_BLOCK = pgftl_pkg::PAGES_PER_BLOCK_DEF,
    parameter int LOGICAL_PAGES   = pgftl_pkg::LOGICAL_PAGES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // opcode[1:0], logical_page[8:2], zero fill
    input  logic [pgftl_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // command[2:0], target_block[6:3], target_page[9:7], source_block[13:10],
    // source_page[16:14], mapped_page[23:17], room_error[24], zero fill
    output logic [pgftl_pkg::OUT_W-1:0] m_axis_tdata,
    output logic                        m_axis_tlast
);

    localparam int BW = $clog2(PHYSICAL_BLOCKS);
    localparam int PW = $clog2(PAGES_PER_BLOCK);
    localparam int PA = BW + PW;
    localparam int PD = PHYSICAL_BLOCKS << PW;
    localparam int LW = $clog2(LOGICAL_PAGES);
    localparam int FW = $clog2(PHYSICAL_BLOCKS + 1);

    pgftl_pkg::out_t out_item;
    logic            lm_we, lm_re, pm_we, pm_re;
    logic [LW-1:0]   lm_waddr, lm_raddr;
    logic [PA-1:0]   lm_wdata, lm_rdata;
    logic [PA-1:0]   pm_waddr, pm_raddr;
    logic [LW+1:0]   pm_wdata, pm_rdata;
    logic [FW-1:0]   free_count;
    logic [PHYSICAL_BLOCKS-1:0] free_mask;

    pgftl_ram #(.WIDTH(PA), .DEPTH(LOGICAL_PAGES)) u_lmap (
        .clk(clk), .we(lm_we), .waddr(lm_waddr), .wdata(lm_wdata),
        .re(lm_re), .raddr(lm_raddr), .rdata(lm_rdata)
    );

    pgftl_ram #(.WIDTH(LW + 2), .DEPTH(PD)) u_pmap (
        .clk(clk), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
        .re(pm_re), .raddr(pm_raddr), .rdata(pm_rdata)
    );

    pgftl_ctrl #(
        .PHYSICAL_BLOCKS(PHYSICAL_BLOCKS),
        .PAGES_PER_BLOCK(PAGES_PER_BLOCK),
        .LOGICAL_PAGES(LOGICAL_PAGES)
    ) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_opcode(s_axis_tdata[1:0]), .in_lpage(s_axis_tdata[8:2]),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_item(out_item),
        .lm_we(lm_we), .lm_waddr(lm_waddr), .lm_wdata(lm_wdata),
        .lm_re(lm_re), .lm_raddr(lm_raddr), .lm_rdata(lm_rdata),
        .pm_we(pm_we), .pm_waddr(pm_waddr), .pm_wdata(pm_wdata),
        .pm_re(pm_re), .pm_raddr(pm_raddr), .pm_rdata(pm_rdata),
        .free_count(free_count), .free_mask(free_mask)
    );

    assign m_axis_tdata = {7'd0, out_item.room_error, out_item.mapped_page,
                           out_item.source_page, out_item.source_block,
                           out_item.target_page, out_item.target_block,
                           out_item.command};
    assign m_axis_tlast = out_item.last;

    // The erased-block count always matches the free flags.
    a_free_count: assert property (@(posedge clk) disable iff (!rst_n)
        32'(free_count) == $countones(free_mask))
        else $error("free block count disagrees with free flags");

    a_free_max: assert property (@(posedge clk) disable iff (!rst_n)
        32'(free_count) <= PHYSICAL_BLOCKS)
        else $error("free block count out of range");

    // An accepted write takes the block out of the idle state and so drops its ready.
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] == pgftl_pkg::OP_WRITE
        |=> !s_axis_tready)
        else $error("write accepted without entering the sequencer");

    a_read_no_room: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (out_item.command == pgftl_pkg::CMD_READ
                          || out_item.command == pgftl_pkg::CMD_UNMAPPED
                          || out_item.command == pgftl_pkg::CMD_FORMAT_DONE)
        |-> !out_item.room_error && out_item.last)
        else $error("read or format result carries collection status");

endmodule
